### design/thumb_alu_flag_executor_core_defines.svh
// ---------------------------------------------------------------------------
// thumb alu flag executor assertion macros
// shared property forms for the checker of the executor core
// ---------------------------------------------------------------------------
`ifndef THUMB_ALU_FLAG_EXECUTOR_CORE_DEFINES_SVH
`define THUMB_ALU_FLAG_EXECUTOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TAF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TAF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/taf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// taf_pkg
// types and constants shared by the thumb alu flag executor
// ---------------------------------------------------------------------------
package taf_pkg;

	localparam int unsigned DATA_W   = 32;
	localparam int unsigned IDX_W    = 4;
	localparam int unsigned REQ_W    = 3;
	localparam int unsigned AMT_W    = 8;
	localparam int unsigned FLAG_W   = 4;
	localparam logic [AMT_W-1:0] LSL_FULL = 8'd32;

	// request kinds
	typedef enum logic [REQ_W-1:0] {
		REQ_ANDS      = 3'd0,
		REQ_ADCS      = 3'd1,
		REQ_ADDS      = 3'd2,
		REQ_BICS      = 3'd3,
		REQ_LSLS      = 3'd4,
		REQ_ASRS      = 3'd5,
		REQ_WRITE_REG = 3'd6,
		REQ_WRITE_FLG = 3'd7
	} taf_req_t;

	// nzcv, n in the top bit
	typedef struct packed {
		logic n;
		logic z;
		logic c;
		logic v;
	} taf_flags_t;

	// what the alu hands back to the pipeline
	typedef struct packed {
		logic [DATA_W-1:0] result;
		taf_flags_t        flags;
		logic              reg_write;
	} taf_alu_out_t;

endpackage

### design/thumb_alu_flag_executor_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// thumb_alu_flag_executor_core
// thumb alu executor on a ram register file with nzcv flags
// ---------------------------------------------------------------------------
// channel  handshake                 payload
// req      req_valid / req_stall     req_type dest_index src_index write_value
// rsp      rsp_valid / rsp_stall     result_value flag_n flag_z flag_c flag_v
//
// one item per cycle while req_stall is low; a result is offered after the
// request stage (register file read) and output register (alu, write back)
// back-to-back dependent items are served by forwarding the last write back
// reset clears the per-register valid bits and the flags, no clearing pass
// req_stall rises only while a result is held in the output register and the
// alu stage is occupied
// ---------------------------------------------------------------------------
module thumb_alu_flag_executor_core
	import taf_pkg::*;
#(
	parameter int unsigned REG_COUNT = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [IDX_W-1:0]  dest_index,
	input  logic [IDX_W-1:0]  src_index,
	input  logic [DATA_W-1:0] write_value,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [DATA_W-1:0] result_value,
	output logic              flag_n,
	output logic              flag_z,
	output logic              flag_c,
	output logic              flag_v
);

	localparam int unsigned ADDR_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam logic [IDX_W:0] REG_LIMIT = (IDX_W + 1)'(REG_COUNT);

	logic                 req_xfer;
	logic                 s1_fire;
	logic                 out_free;

	logic                 valid_s1;
	logic [REQ_W-1:0]     req_type_s1;
	logic [IDX_W-1:0]     dest_index_s1;
	logic [IDX_W-1:0]     src_index_s1;
	logic [DATA_W-1:0]    write_value_s1;

	logic [REG_COUNT-1:0] entry_valid_q;
	taf_flags_t           flags_q;

	logic                 wb_en_q;
	logic [IDX_W-1:0]     wb_index_q;
	logic [DATA_W-1:0]    wb_data_q;

	logic                 rsp_valid_q;
	logic [DATA_W-1:0]    result_q;
	taf_flags_t           rsp_flags_q;

	logic [DATA_W-1:0]    ram_a;
	logic [DATA_W-1:0]    ram_b;
	logic                 dest_ok;
	logic                 src_ok;
	logic [DATA_W-1:0]    op_a;
	logic [DATA_W-1:0]    op_b;
	logic                 rf_wr_en;
	taf_alu_out_t         alu_out;

	// handshake
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign s1_fire   = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;
	assign req_xfer  = req_valid && !req_stall;

	// two copies of the register file, one per operand
	taf_ram #(
		.WIDTH  (DATA_W),
		.DEPTH  (REG_COUNT),
		.ADDR_W (ADDR_W)
	) u_rf_a (
		.clk     (clk),
		.wr_en   (rf_wr_en),
		.wr_addr (dest_index_s1[ADDR_W-1:0]),
		.wr_data (alu_out.result),
		.rd_en   (req_xfer),
		.rd_addr (dest_index[ADDR_W-1:0]),
		.rd_data (ram_a)
	);

	taf_ram #(
		.WIDTH  (DATA_W),
		.DEPTH  (REG_COUNT),
		.ADDR_W (ADDR_W)
	) u_rf_b (
		.clk     (clk),
		.wr_en   (rf_wr_en),
		.wr_addr (dest_index_s1[ADDR_W-1:0]),
		.wr_data (alu_out.result),
		.rd_en   (req_xfer),
		.rd_addr (src_index[ADDR_W-1:0]),
		.rd_data (ram_b)
	);

	// request stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			req_type_s1    <= req_type;
			dest_index_s1  <= dest_index;
			src_index_s1   <= src_index;
			write_value_s1 <= write_value;
		end
	end

	// operand select: range check, forwarding, never-written entries read zero
	assign dest_ok = {1'b0, dest_index_s1} < REG_LIMIT;
	assign src_ok  = {1'b0, src_index_s1} < REG_LIMIT;

	always_comb begin
		if (!dest_ok) begin
			op_a = '0;
		end else if (wb_en_q && wb_index_q == dest_index_s1) begin
			op_a = wb_data_q;
		end else if (entry_valid_q[dest_index_s1[ADDR_W-1:0]]) begin
			op_a = ram_a;
		end else begin
			op_a = '0;
		end
		if (!src_ok) begin
			op_b = '0;
		end else if (wb_en_q && wb_index_q == src_index_s1) begin
			op_b = wb_data_q;
		end else if (entry_valid_q[src_index_s1[ADDR_W-1:0]]) begin
			op_b = ram_b;
		end else begin
			op_b = '0;
		end
	end

	taf_alu u_alu (
		.req_type    (taf_req_t'(req_type_s1)),
		.op_a        (op_a),
		.op_b        (op_b),
		.write_value (write_value_s1),
		.flags_in    (flags_q),
		.alu_out     (alu_out)
	);

	assign rf_wr_en = s1_fire && alu_out.reg_write && dest_ok;

	// valid bits, flags and the forwarding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			flags_q       <= '0;
			wb_en_q       <= 1'b0;
		end else if (s1_fire) begin
			if (rf_wr_en) begin
				entry_valid_q[dest_index_s1[ADDR_W-1:0]] <= 1'b1;
			end
			flags_q <= alu_out.flags;
			wb_en_q <= rf_wr_en;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			wb_index_q <= dest_index_s1;
			wb_data_q  <= alu_out.result;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			result_q    <= alu_out.result;
			rsp_flags_q <= alu_out.flags;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign result_value = result_q;
	assign flag_n       = rsp_flags_q.n;
	assign flag_z       = rsp_flags_q.z;
	assign flag_c       = rsp_flags_q.c;
	assign flag_v       = rsp_flags_q.v;

endmodule

### design/taf_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// taf_ram
// generic single write port ram with one registered read port
// ---------------------------------------------------------------------------
module taf_ram #(
	parameter int unsigned WIDTH  = 32,
	parameter int unsigned DEPTH  = 16,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### design/taf_alu.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// taf_alu
// thumb two-register alu with nzcv flag update
// ---------------------------------------------------------------------------
module taf_alu
	import taf_pkg::*;
(
	input  taf_req_t          req_type,
	input  logic [DATA_W-1:0] op_a,
	input  logic [DATA_W-1:0] op_b,
	input  logic [DATA_W-1:0] write_value,
	input  taf_flags_t        flags_in,
	output taf_alu_out_t      alu_out
);

	logic [AMT_W-1:0]      amt;
	logic [DATA_W:0]       sum;
	logic                  cin;
	logic [2*DATA_W-1:0]   lsl_wide;
	logic [DATA_W:0]       asr_wide;
	logic [DATA_W-1:0]     res;
	logic                  sign_a;

	assign amt    = op_b[AMT_W-1:0];
	assign sign_a = op_a[DATA_W-1];
	assign cin    = (req_type == REQ_ADCS) ? flags_in.c : 1'b0;

	// adder, carry out lands in the top bit
	assign sum = {1'b0, op_a} + {1'b0, op_b} + {{DATA_W{1'b0}}, cin};

	// left shift through a double-width word, bit DATA_W is the last bit out
	assign lsl_wide = {{DATA_W{1'b0}}, op_a} << amt[5:0];

	// arithmetic right shift with one guard bit below for the carry
	assign asr_wide = $signed({op_a, 1'b0}) >>> amt[4:0];

	// operation select and flag update
	always_comb begin
		res               = op_a;
		alu_out.flags     = flags_in;
		alu_out.reg_write = 1'b1;
		unique case (req_type) inside
			REQ_ANDS: begin
				res = op_a & op_b;
			end
			REQ_BICS: begin
				res = op_a & ~op_b;
			end
			REQ_ADDS, REQ_ADCS: begin
				res             = sum[DATA_W-1:0];
				alu_out.flags.c = sum[DATA_W];
				alu_out.flags.v = ~(op_a[DATA_W-1] ^ op_b[DATA_W-1])
					& (op_a[DATA_W-1] ^ sum[DATA_W-1]);
			end
			REQ_LSLS: begin
				if (amt == '0) begin
					res = op_a;
				end else if (amt <= LSL_FULL) begin
					res             = lsl_wide[DATA_W-1:0];
					alu_out.flags.c = lsl_wide[DATA_W];
				end else begin
					res             = '0;
					alu_out.flags.c = 1'b0;
				end
			end
			REQ_ASRS: begin
				if (amt == '0) begin
					res = op_a;
				end else if (amt < LSL_FULL) begin
					res             = asr_wide[DATA_W:1];
					alu_out.flags.c = asr_wide[0];
				end else begin
					res             = {DATA_W{sign_a}};
					alu_out.flags.c = sign_a;
				end
			end
			REQ_WRITE_REG: begin
				res = write_value;
			end
			REQ_WRITE_FLG: begin
				res               = op_a;
				alu_out.reg_write = 1'b0;
			end
			default: begin
				res = op_a;
			end
		endcase
		// n and z follow the result for every alu operation
		if (req_type != REQ_WRITE_REG && req_type != REQ_WRITE_FLG) begin
			alu_out.flags.n = res[DATA_W-1];
			alu_out.flags.z = (res == '0);
		end
		if (req_type == REQ_WRITE_FLG) begin
			alu_out.flags = taf_flags_t'(write_value[FLAG_W-1:0]);
		end
		alu_out.result = res;
	end

endmodule

### design/taf_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// taf_checker
// port-level checks on the thumb alu flag executor core
// ---------------------------------------------------------------------------
`include "thumb_alu_flag_executor_core_defines.svh"

module taf_checker
	import taf_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input logic [DATA_W-1:0] result_value,
	input logic              flag_n,
	input logic              flag_z,
	input logic              flag_c,
	input logic              flag_v
);

	// a held result keeps its payload
	`TAF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
		rsp_valid && $stable(result_value) && $stable(flag_n) && $stable(flag_z)
		&& $stable(flag_c) && $stable(flag_v), "held response changed")

	// the request side only backs up behind a stalled result
	`TAF_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall,
		"request stalled without a stalled response")

	// every request transfer is followed by rsp_valid, past the request stage and output register
	`TAF_ASSERT_NOW(a_rsp_latency, req_valid && !req_stall, ##2 rsp_valid,
		"no response after a request transfer")

endmodule

bind thumb_alu_flag_executor_core taf_checker u_taf_checker (.*);
